// File: rtl/core/acp_pkg.sv
// ----------------------------------------------------------------------------
// acp_pkg
// Shared types, character codes and helpers for the ADD command parser.
// ----------------------------------------------------------------------------
package acp_pkg;

    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_D     = 8'h44;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_NL    = 8'h0A;

    // Keyword is three characters; match count runs 0..2 before entry
    localparam logic [1:0] KEY_LAST   = 2'd2;
    // Two prefix characters ("0x") skipped ahead of the digits
    localparam logic [1:0] PREFIX_LEN = 2'd2;

    localparam logic [1:0] FIELD_NONE   = 2'd0;
    localparam logic [1:0] FIELD_FIRST  = 2'd1;
    localparam logic [1:0] FIELD_SECOND = 2'd2;

    typedef enum logic {
        MODE_SCAN,
        MODE_OPERANDS
    } t_mode;

    // Per-operand control from the parser
    typedef struct packed {
        logic clear;
        logic feed;
    } t_opnd_ctl;

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CH_SPACE) || (c == CH_NL);
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]});
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        logic [7:0] d;
        if (c inside {[8'h30:8'h39]}) begin
            d = c - 8'h30;
        end else if (c inside {[8'h41:8'h46]}) begin
            d = c - 8'h37;
        end else begin
            d = c - 8'h57;
        end
        return d[3:0];
    endfunction

endpackage

// File: rtl/core/acp_operand.sv
// ----------------------------------------------------------------------------
// acp_operand
// One hex operand accumulator: skips the two-character prefix, shifts in hex
// digits and freezes on the first non-hex character.
// ----------------------------------------------------------------------------
module acp_operand
    import acp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_opnd_ctl   i_ctl,
    input  logic [7:0]  i_ch,
    output logic [31:0] o_acc
);

    logic [31:0] r_acc, n_acc;
    logic [1:0]  r_skipped, n_skipped;
    logic        r_stopped, n_stopped;

    always_comb begin
        n_acc     = r_acc;
        n_skipped = r_skipped;
        n_stopped = r_stopped;
        if (i_ctl.clear) begin
            n_acc     = '0;
            n_skipped = '0;
            n_stopped = 1'b0;
        end else if (i_ctl.feed && !is_blank(i_ch)) begin
            if (r_skipped < PREFIX_LEN) begin
                n_skipped = r_skipped + 2'd1;
            end else if (!r_stopped) begin
                if (is_hex(i_ch)) begin
                    n_acc = {r_acc[27:0], hex_nibble(i_ch)};
                end else begin
                    n_stopped = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc     <= '0;
            r_skipped <= '0;
            r_stopped <= 1'b0;
        end else begin
            r_acc     <= n_acc;
            r_skipped <= n_skipped;
            r_stopped <= n_stopped;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: rtl/core/acp_parser.sv
// ----------------------------------------------------------------------------
// acp_parser
// Keyword scan and field sequencing; steers characters to the operand units
// and flags the end of a command.
// ----------------------------------------------------------------------------
module acp_parser
    import acp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  logic [7:0] i_ch,
    output t_opnd_ctl  o_ctl_first,
    output t_opnd_ctl  o_ctl_second,
    output logic       o_emit
);

    t_mode      r_mode, n_mode;
    logic [1:0] r_match_count, n_match_count;
    logic [1:0] r_field_count, n_field_count;

    logic blank;
    logic hit;

    assign blank = is_blank(i_ch);
    assign hit   = ((i_ch == CH_A) && (r_match_count == 2'd0)) ||
                   ((i_ch == CH_D) && ((r_match_count == 2'd1) ||
                                       (r_match_count == 2'd2)));

    // Next state
    always_comb begin
        n_mode        = r_mode;
        n_match_count = r_match_count;
        n_field_count = r_field_count;
        if (i_step) begin
            case (r_mode)
                MODE_SCAN: begin
                    if (hit && (r_match_count == KEY_LAST)) begin
                        n_mode        = MODE_OPERANDS;
                        n_match_count = '0;
                        n_field_count = FIELD_NONE;
                    end else if (hit) begin
                        n_match_count = r_match_count + 2'd1;
                    end else begin
                        n_match_count = '0;
                    end
                end
                MODE_OPERANDS: begin
                    if ((r_field_count == FIELD_SECOND) && blank) begin
                        n_mode        = MODE_SCAN;
                        n_match_count = '0;
                        n_field_count = FIELD_NONE;
                    end else if (blank && (r_field_count < FIELD_SECOND)) begin
                        n_field_count = r_field_count + 2'd1;
                    end
                end
                default: begin
                    n_mode = MODE_SCAN;
                end
            endcase
        end
    end

    // Outputs
    always_comb begin
        o_ctl_first  = '0;
        o_ctl_second = '0;
        o_emit       = 1'b0;
        if (i_step) begin
            case (r_mode)
                MODE_SCAN: begin
                    if (hit && (r_match_count == KEY_LAST)) begin
                        o_ctl_first.clear  = 1'b1;
                        o_ctl_second.clear = 1'b1;
                    end
                end
                MODE_OPERANDS: begin
                    if (r_field_count == FIELD_FIRST) begin
                        o_ctl_first.feed = 1'b1;
                    end else if (r_field_count == FIELD_SECOND) begin
                        if (blank) begin
                            o_emit             = 1'b1;
                            o_ctl_first.clear  = 1'b1;
                            o_ctl_second.clear = 1'b1;
                        end else begin
                            o_ctl_second.feed = 1'b1;
                        end
                    end
                end
                default: begin
                    o_emit = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_SCAN;
            r_match_count <= '0;
            r_field_count <= FIELD_NONE;
        end else begin
            r_mode        <= n_mode;
            r_match_count <= n_match_count;
            r_field_count <= n_field_count;
        end
    end

    a_emit_in_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |-> (r_mode == MODE_OPERANDS) && (r_field_count == FIELD_SECOND))
        else $error("emit outside second operand field");

    a_emit_back_to_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_emit |=> (r_mode == MODE_SCAN) && (r_match_count == 2'd0))
        else $error("scan mode not resumed after emit");

    a_one_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_ctl_first.feed && o_ctl_second.feed))
        else $error("both operands fed by one character");

    a_field_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_count != 2'd3)
        else $error("field count out of range");

    a_scan_no_feed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_SCAN) |-> !(o_ctl_first.feed || o_ctl_second.feed || o_emit))
        else $error("operand activity during keyword scan");

endmodule

// File: rtl/core/ascii_add_command_parser.sv
// ----------------------------------------------------------------------------
// ascii_add_command_parser
// Parses "ADD 0x<hex> 0x<hex>" from a character stream and returns both
// operands and their 32-bit sum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: one ASCII character per beat on i_ch (i_valid / o_stall).
//   Output channel: one result beat per completed command (o_valid / i_stall)
//   carrying o_first_value, o_second_value and o_sum (wrapped to 32 bits).
//   Most characters produce no result; the blank that ends the second operand
//   produces exactly one.
//   A character lands in the input register at its accept edge and is parsed
//   once no held result blocks it; a result it completes is loaded into the
//   result register at the end of that parse cycle, raising o_valid.
//   Throughput: one character per cycle while o_stall is low, with the state
//   update and shift-add in the parser and operand units done on each step.
//   Stall: while a result waits under i_stall, the input register keeps
//   filling; o_stall rises only once a character is waiting behind a held
//   result. A held result never changes.
//   Reset (synchronous, i_rst_n low): keyword scan with all counts and
//   accumulators cleared; no beat pending on either side.
// ----------------------------------------------------------------------------
module ascii_add_command_parser
    import acp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_ch,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_first_value,
    output logic [31:0] o_second_value,
    output logic [31:0] o_sum
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_in_ch;

    // Result register
    logic        r_out_valid;
    logic [31:0] r_out_first;
    logic [31:0] r_out_second;
    logic [31:0] r_out_sum;

    logic        advance;   // result slot free (or freeing) this cycle
    logic        step;      // registered character is consumed
    logic        in_take;   // input beat accepted
    logic        emit;
    t_opnd_ctl   ctl_first;
    t_opnd_ctl   ctl_second;
    logic [31:0] first_acc;
    logic [31:0] second_acc;

    assign advance = !r_out_valid || !i_stall;
    assign step    = r_in_valid && advance;
    assign o_stall = r_in_valid && !advance;
    assign in_take = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_ch <= i_ch;
        end
    end

    acp_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_step       (step),
        .i_ch         (r_in_ch),
        .o_ctl_first  (ctl_first),
        .o_ctl_second (ctl_second),
        .o_emit       (emit)
    );

    acp_operand u_first (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_first),
        .i_ch    (r_in_ch),
        .o_acc   (first_acc)
    );

    acp_operand u_second (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl_second),
        .i_ch    (r_in_ch),
        .o_acc   (second_acc)
    );

    // Emit only happens on a step, so the slot is free whenever it loads.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_first  <= first_acc;
            r_out_second <= second_acc;
            r_out_sum    <= first_acc + second_acc;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_first_value  = r_out_first;
    assign o_second_value = r_out_second;
    assign o_sum          = r_out_sum;

endmodule

// File: test/ascii_add_command_parser_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_add_command_parser_tb
// Self-checking bench for the ADD command parser. A character stream of
// directed text and random commands (clean, noisy and broken) is driven one
// beat at a time. A cycle-free model of the parser predicts every result
// beat, and the monitor checks each one, field by field, in order.
// ----------------------------------------------------------------------------
module ascii_add_command_parser_tb;

    import acp_pkg::*;

    localparam int unsigned CHAR_TARGET  = 1000;  // random stream length
    localparam int unsigned IDLE_MAX     = 6;     // per-beat gap / stall draw
    localparam int unsigned LONG_HOLD    = 80;    // receiver hold-off, cycles
    localparam int unsigned DRAIN_CYCLES = 8;     // tail after last result
    localparam int unsigned STUCK_LIMIT  = 1000;  // cycles with no beat moved

    // One character beat as the driver sees it
    typedef struct {
        logic [7:0]  ch;
        int unsigned gap;    // idle cycles after this beat
        bit          drain;  // hold this beat until no result is outstanding
    } t_char_beat;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
        logic [31:0] total;
    } t_add_result;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic [7:0]  i_ch    = 8'h00;
    logic        i_stall = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [31:0] o_first_value;
    logic [31:0] o_second_value;
    logic [31:0] o_sum;

    ascii_add_command_parser dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ch           (i_ch),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_first_value  (o_first_value),
        .o_second_value (o_second_value),
        .o_sum          (o_sum)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Parser model: mirrors the keyword scan and operand state of the block.
    // Runs once per accepted character and queues the sum it completes.
    // ------------------------------------------------------------------------
    t_mode       parse_mode = MODE_SCAN;
    logic [1:0]  key_hits   = 2'd0;
    logic [1:0]  field_sel  = FIELD_NONE;
    logic [31:0] opnd_acc  [2];
    logic [1:0]  opnd_skip [2];
    logic        opnd_stop [2];

    t_add_result sum_q  [$];   // results still owed by the block
    t_char_beat  char_q [$];   // characters not yet offered

    int unsigned chars_total = 0;
    int unsigned chars_taken = 0;
    int unsigned sums_seen   = 0;
    int unsigned errors      = 0;

    task automatic clear_operands();
        field_sel = FIELD_NONE;
        for (int k = 0; k < 2; k++) begin
            opnd_acc[k]  = '0;
            opnd_skip[k] = '0;
            opnd_stop[k] = 1'b0;
        end
    endtask

    // {is_hex, nibble}
    function automatic logic [4:0] decode_hex_digit(input logic [7:0] c);
        logic [7:0] v;
        v = 8'h00;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "A" && c <= "F") begin
            v = c - "A" + 8'd10;
        end else if (c >= "a" && c <= "f") begin
            v = c - "a" + 8'd10;
        end else begin
            return 5'b0_0000;
        end
        return {1'b1, v[3:0]};
    endfunction

    // Prefix skip, then digits until the first non-hex; blanks never count
    task automatic shift_digit(input int k, input logic [7:0] c);
        logic [4:0] d;
        d = decode_hex_digit(c);
        if (c == CH_SPACE || c == CH_NL) begin
            return;
        end
        if (opnd_skip[k] < PREFIX_LEN) begin
            opnd_skip[k] = opnd_skip[k] + 2'd1;
        end else if (!opnd_stop[k]) begin
            if (d[4]) begin
                opnd_acc[k] = {opnd_acc[k][27:0], d[3:0]};
            end else begin
                opnd_stop[k] = 1'b1;
            end
        end
    endtask

    task automatic parse_char(input logic [7:0] c);
        logic        blank;
        logic        hit;
        t_add_result r;
        blank = (c == CH_SPACE) || (c == CH_NL);
        if (parse_mode == MODE_SCAN) begin
            // a failed character clears the count and is not retried as 'A'
            hit = (c == CH_A && key_hits == 2'd0) ||
                  (c == CH_D && (key_hits == 2'd1 || key_hits == 2'd2));
            if (!hit) begin
                key_hits = 2'd0;
            end else if (key_hits == KEY_LAST) begin
                parse_mode = MODE_OPERANDS;
                key_hits   = 2'd0;
                clear_operands();
            end else begin
                key_hits = key_hits + 2'd1;
            end
        end else if (field_sel == FIELD_SECOND && blank) begin
            r.first  = opnd_acc[0];
            r.second = opnd_acc[1];
            r.total  = opnd_acc[0] + opnd_acc[1];
            sum_q.push_back(r);
            parse_mode = MODE_SCAN;
            key_hits   = 2'd0;
            clear_operands();
        end else begin
            if (field_sel == FIELD_FIRST) begin
                shift_digit(0, c);
            end else if (field_sel == FIELD_SECOND) begin
                shift_digit(1, c);
            end
            // blanks before the second field advance it
            if (blank) begin
                field_sel = field_sel + 2'd1;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stream building
    // ------------------------------------------------------------------------
    int unsigned gap_max   = 0;   // 0 gives a back-to-back stretch
    bit          drain_nxt = 1'b0;

    task automatic push_char(input logic [7:0] c);
        t_char_beat b;
        b.ch    = c;
        b.gap   = $urandom_range(0, gap_max);
        b.drain = drain_nxt;
        drain_nxt = 1'b0;
        char_q.push_back(b);
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) begin
            push_char(s[k]);
        end
    endtask

    function automatic logic [7:0] rand_blank();
        return $urandom_range(0, 1) ? CH_SPACE : CH_NL;
    endfunction

    function automatic logic [7:0] rand_nonblank();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == CH_SPACE || c == CH_NL);
        return c;
    endfunction

    // Ends a number: not hex, not blank
    function automatic logic [7:0] rand_stop_char();
        logic [7:0] c;
        do begin
            c = rand_nonblank();
        end while (decode_hex_digit(c) != 5'b0_0000);
        return c;
    endfunction

    // Bias toward keyword letters so partial matches show up in scan mode
    function automatic logic [7:0] rand_noise();
        logic [7:0] c;
        case ($urandom_range(0, 4))
            0:       c = CH_A;
            1:       c = CH_D;
            2:       c = rand_blank();
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return "0" + v;
        end
        return ($urandom_range(0, 1) ? "a" : "A") + (v - 4'd10);
    endfunction

    task automatic queue_operand();
        int unsigned pick;
        int unsigned ndig;
        logic [3:0]  v;
        if ($urandom_range(0, 7) == 0) begin
            // prefix slots take anything non-blank
            push_char(rand_nonblank());
            push_char(rand_nonblank());
        end else begin
            push_char("0");
            push_char($urandom_range(0, 1) ? "x" : "X");
        end
        pick = $urandom_range(0, 15);
        if (pick == 0) begin
            ndig = 0;
        end else if (pick == 1) begin
            ndig = $urandom_range(9, 12);   // overflow keeps the low word
        end else begin
            ndig = $urandom_range(1, 8);
        end
        repeat (ndig) begin
            v = (pick == 2) ? 4'hF : 4'($urandom_range(0, 15));
            push_char(hex_char(v));
        end
        if ($urandom_range(0, 3) == 0) begin
            // stop char, then trailing junk that must be ignored
            push_char(rand_stop_char());
            repeat ($urandom_range(0, 3)) push_char(rand_nonblank());
        end
    endtask

    task automatic queue_command();
        gap_max = ($urandom_range(0, 3) == 0) ? 0 : IDLE_MAX;
        repeat ($urandom_range(0, 3)) push_char(rand_noise());
        push_text("ADD");
        if ($urandom_range(0, 7) == 0) begin
            push_char(rand_nonblank());     // ignored before the first field
        end
        push_char(rand_blank());
        if ($urandom_range(0, 15) == 0) begin
            push_char(rand_blank());        // empty first operand
        end
        queue_operand();
        push_char(rand_blank());
        if ($urandom_range(0, 19) == 0) begin
            return;                         // broken: next text lands in operand 2
        end
        queue_operand();
        push_char(rand_blank());
    endtask

    // ------------------------------------------------------------------------
    // Driver: offers queued characters, holds a beat while o_stall is high
    // ------------------------------------------------------------------------
    int unsigned tx_idle = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_idle = 0;
        end else begin
            if (i_valid && !o_stall) begin
                parse_char(i_ch);
                chars_taken++;
            end
            if (!(i_valid && o_stall)) begin
                if (tx_idle > 0) begin
                    tx_idle--;
                    i_valid <= 1'b0;
                end else if (char_q.size() != 0 &&
                             !(char_q[0].drain && sum_q.size() != 0)) begin
                    i_valid <= 1'b1;
                    i_ch    <= char_q[0].ch;
                    tx_idle = char_q[0].gap;
                    char_q.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: random stall after each result beat, calm stretches, and two
    // long hold-offs that back the block up into its input. A long hold-off
    // only counts down while a result is waiting, so the input always fills.
    // ------------------------------------------------------------------------
    int unsigned rx_wait = 0;
    bit          rx_calm = 1'b0;
    bit          rx_long = 1'b0;

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_add_result want;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
            rx_long = 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (sum_q.size() == 0) begin
                    $error("result beat with none pending: %h + %h = %h",
                           o_first_value, o_second_value, o_sum);
                    errors++;
                end else begin
                    want = sum_q.pop_front();
                    check_field("first_value",  want.first,  o_first_value);
                    check_field("second_value", want.second, o_second_value);
                    check_field("sum",          want.total,  o_sum);
                end
                sums_seen++;
                rx_long = 1'b0;
                if (sums_seen == 6 || sums_seen == 30) begin
                    rx_wait = LONG_HOLD;
                    rx_long = 1'b1;
                end else if (rx_calm) begin
                    rx_wait = 0;
                end else begin
                    rx_wait = $urandom_range(0, IDLE_MAX);
                end
                if ($urandom_range(0, 9) == 0) begin
                    rx_calm = !rx_calm;
                end
            end else if (rx_wait > 0 && (o_valid || !rx_long)) begin
                rx_wait--;
            end
            i_stall <= (rx_wait != 0);
        end
    end

    // Watchdog: no beat on either side for too long
    int unsigned stuck_cycles = 0;

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
        end
        if (stuck_cycles == STUCK_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        int unsigned cmd_no;
        // Directed: a failed 'A' is not retried, newline as separator,
        // all-ones operand and a sum that wraps to zero
        gap_max = 0;
        push_text("AADDADD\n0xFFFFFFFF 0x1 ");
        cmd_no = 0;
        while (char_q.size() < CHAR_TARGET) begin
            // sender pauses here until every owed result is back
            if (cmd_no == 12 || cmd_no == 35) begin
                drain_nxt = 1'b1;
            end
            queue_command();
            cmd_no++;
        end
        chars_total = char_q.size();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (chars_taken != chars_total) @(posedge i_clk);
        while (sum_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
